### hdl/tire_sensor_payload_parser_core_assert.svh
// assertion macros for the tire sensor payload parser
`ifndef TIRE_SENSOR_PAYLOAD_PARSER_CORE_ASSERT_SVH
`define TIRE_SENSOR_PAYLOAD_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TSPP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tspp assertion failed");
`define TSPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tspp assertion failed");
`else
`define TSPP_ASSERT(lbl, prop)
`define TSPP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/tspp_pkg.sv
// shared types and constants for the tire sensor payload parser
package tspp_pkg;

    localparam logic [31:0] HEADER_WORD   = 32'h0308_4252;
    localparam logic [15:0] PRESS_MIN_RAW = 16'd148;
    localparam logic [15:0] PRESS_FORCED  = 16'd146;
    localparam logic [15:0] PRESS_ZERO    = 16'd145;
    localparam logic [19:0] PRESS_SCALE   = 20'd655532;

    localparam logic [3:0] OFF_FIRST = 4'd3;
    localparam logic [3:0] OFF_VOLT  = 4'd7;
    localparam logic [3:0] OFF_TEMP  = 4'd8;
    localparam logic [3:0] OFF_PHI   = 4'd9;
    localparam logic [3:0] OFF_PLO   = 4'd10;
    localparam logic [3:0] OFF_END   = 4'd11;

    typedef struct packed {
        logic        ok;
        logic [7:0]  voltage;
        logic [7:0]  temperature;
        logic [15:0] pressure;
    } frame_t;

endpackage

### hdl/tspp_parser.sv
// per-byte header search, field capture and frame summary register
`include "tire_sensor_payload_parser_core_assert.svh"

module tspp_parser #(
    parameter int MAX_PAYLOAD_BYTES = 255
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output logic             frm_valid,
    input  logic             frm_ready,
    output tspp_pkg::frame_t frm
);

    localparam int PosW = $clog2(MAX_PAYLOAD_BYTES + 1);

    logic [PosW-1:0]  pos_reg, pos_next;
    logic [23:0]      recent_reg, recent_next;
    logic             found_reg, found_next;
    logic [3:0]       off_reg, off_next;
    logic [7:0]       volt_reg, volt_next;
    logic [7:0]       temp_reg, temp_next;
    logic [15:0]      press_reg, press_next;
    logic             frm_valid_reg, frm_valid_next;
    tspp_pkg::frame_t frm_reg, frm_next;

    logic             in_fire;
    logic             active;
    logic [3:0]       off_inc;

    assign in_ready  = !in_last || !frm_valid_reg || frm_ready;
    assign in_fire   = in_valid && in_ready;
    assign active    = pos_reg != PosW'(MAX_PAYLOAD_BYTES);
    assign off_inc   = off_reg + 4'd1;
    assign frm_valid = frm_valid_reg;
    assign frm       = frm_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        recent_next = recent_reg;
        found_next  = found_reg;
        off_next    = off_reg;
        volt_next   = volt_reg;
        temp_next   = temp_reg;
        press_next  = press_reg;
        frm_next    = '0;
        if (in_fire && active)
        begin
            pos_next    = pos_reg + PosW'(1);
            recent_next = {recent_reg[15:0], in_byte};
            if (!found_reg)
            begin
                if ({recent_reg, in_byte} == tspp_pkg::HEADER_WORD)
                begin
                    found_next = 1'b1;
                    off_next   = tspp_pkg::OFF_FIRST;
                end
            end
            else if (off_reg < tspp_pkg::OFF_END)
            begin
                off_next = off_inc;
                case (off_inc)
                    tspp_pkg::OFF_VOLT: volt_next = in_byte;
                    tspp_pkg::OFF_TEMP: temp_next = in_byte;
                    tspp_pkg::OFF_PHI:  press_next = {in_byte, press_reg[7:0]};
                    tspp_pkg::OFF_PLO:  press_next = {press_reg[15:8], in_byte};
                    default:            ;
                endcase
            end
        end
        if (found_next && off_next >= tspp_pkg::OFF_PLO)
        begin
            frm_next.ok          = 1'b1;
            frm_next.voltage     = volt_next;
            frm_next.temperature = temp_next;
            frm_next.pressure    = (press_next < tspp_pkg::PRESS_MIN_RAW) ?
                                   tspp_pkg::PRESS_FORCED : press_next;
        end
        // packet closes: clear per-packet state
        if (in_fire && in_last)
        begin
            pos_next    = '0;
            recent_next = '0;
            found_next  = 1'b0;
            off_next    = '0;
            volt_next   = '0;
            temp_next   = '0;
            press_next  = '0;
        end
    end

    always_comb
    begin
        if (in_fire && in_last)
        begin
            frm_valid_next = 1'b1;
        end
        else if (frm_ready)
        begin
            frm_valid_next = 1'b0;
        end
        else
        begin
            frm_valid_next = frm_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            recent_reg    <= '0;
            found_reg     <= 1'b0;
            off_reg       <= '0;
            volt_reg      <= '0;
            temp_reg      <= '0;
            press_reg     <= '0;
            frm_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            recent_reg    <= recent_next;
            found_reg     <= found_next;
            off_reg       <= off_next;
            volt_reg      <= volt_next;
            temp_reg      <= temp_next;
            press_reg     <= press_next;
            frm_valid_reg <= frm_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_last)
        begin
            frm_reg <= frm_next;
        end
    end

    `TSPP_ASSERT_NEXT(a_clear_after_last, in_fire && in_last, pos_reg == '0 && !found_reg && off_reg == '0)
    `TSPP_ASSERT(a_offset_range, off_reg <= tspp_pkg::OFF_END)
    `TSPP_ASSERT(a_offset_found, (found_reg && off_reg >= tspp_pkg::OFF_FIRST) || (!found_reg && off_reg == '0))
    `TSPP_ASSERT(a_frame_clamp, !(frm_valid_reg && frm_reg.ok) || frm_reg.pressure >= tspp_pkg::PRESS_FORCED)

endmodule

### hdl/tspp_convert.sv
// pressure scaling and result register
module tspp_convert (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frm_valid,
    output logic             frm_ready,
    input  tspp_pkg::frame_t frm,
    output logic             res_valid,
    input  logic             res_ready,
    output logic             res_ok,
    output logic [7:0]       res_voltage,
    output logic [7:0]       res_temperature,
    output logic [15:0]      res_pressure,
    output logic [19:0]      res_centipsi
);

    logic        out_valid_reg, out_valid_next;
    logic        ok_reg;
    logic [7:0]  volt_reg;
    logic [7:0]  temp_reg;
    logic [15:0] press_reg;
    logic [19:0] centi_reg;

    logic        load;
    logic [15:0] gauge;
    logic [35:0] product;

    assign frm_ready = !out_valid_reg || res_ready;
    assign load      = frm_valid && frm_ready;
    assign gauge     = frm.pressure - tspp_pkg::PRESS_ZERO;
    assign product   = {20'd0, gauge} * {16'd0, tspp_pkg::PRESS_SCALE};

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg    <= frm.ok;
            volt_reg  <= frm.voltage;
            temp_reg  <= frm.temperature;
            press_reg <= frm.pressure;
            centi_reg <= frm.ok ? product[35:16] : 20'd0;
        end
    end

    assign res_valid       = out_valid_reg;
    assign res_ok          = ok_reg;
    assign res_voltage     = volt_reg;
    assign res_temperature = temp_reg;
    assign res_pressure    = press_reg;
    assign res_centipsi    = centi_reg;

endmodule

### hdl/tire_sensor_payload_parser_core.sv
// top level of the tire sensor payload parser
// Takes one payload byte per transfer on the slave side and gives one result per
// payload on the master side, in the transfer after the byte marked tlast. A byte is
// taken in every cycle unless a tlast byte waits on a full frame register that is not
// yet taken; the block runs as three registered stages (input register, header search
// and capture into a frame register, pressure multiply into the result register).
// Only the first 03 08 'B' 'R' header of a payload counts; bytes past
// MAX_PAYLOAD_BYTES are dropped but tlast still closes the payload. m_tuser is set
// when the header and all eleven frame bytes arrived; otherwise every field is zero.
module tire_sensor_payload_parser_core #(
    parameter int MAX_PAYLOAD_BYTES = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // data_byte
    input  logic        s_tlast,  // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // voltage_tenths, temperature_deg, pressure_word,
                                  // pressure_centipsi, zero pad
    output logic [0:0]  m_tuser   // frame_valid
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             in_take;

    logic             frm_valid;
    logic             frm_ready;
    tspp_pkg::frame_t frm;

    logic             res_ok;
    logic [7:0]       res_voltage;
    logic [7:0]       res_temperature;
    logic [15:0]      res_pressure;
    logic [19:0]      res_centipsi;

    assign s_tready = !in_valid_reg || in_take;

    always_comb
    begin
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (in_take)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    tspp_parser #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (in_take),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm       (frm)
    );

    tspp_convert u_convert (
        .clk             (clk),
        .rst_n           (rst_n),
        .frm_valid       (frm_valid),
        .frm_ready       (frm_ready),
        .frm             (frm),
        .res_valid       (m_tvalid),
        .res_ready       (m_tready),
        .res_ok          (res_ok),
        .res_voltage     (res_voltage),
        .res_temperature (res_temperature),
        .res_pressure    (res_pressure),
        .res_centipsi    (res_centipsi)
    );

    assign m_tdata = {4'd0, res_centipsi, res_pressure, res_temperature, res_voltage};
    assign m_tuser = res_ok;

endmodule
